@@ src/mnsp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mnsp_pkg: shared types and constants for the MIDI note stream parser
// Phase encoding, result kinds and sizes used by the parser and its divider.
// ----------------------------------------------------------------------------
package mnsp_pkg;

  localparam int unsigned TickSumWidth = 32;
  localparam int unsigned BpmWidth     = 26;
  localparam logic [25:0] MicrosPerMin = 26'd60000000;

  typedef enum logic [2:0] {
    KIND_HEADER  = 3'd0,
    KIND_TEMPO   = 3'd1,
    KIND_NOTE    = 3'd2,
    KIND_BAD_MRK = 3'd3,
    KIND_END     = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    SUB_DELTA = 4'd0,
    SUB_STATUS = 4'd1,
    SUB_KEY = 4'd2,
    SUB_VEL = 4'd3,
    SUB_SKIP = 4'd4,
    SUB_MKIND = 4'd5,
    SUB_MLEN = 4'd6,
    SUB_TLEN = 4'd7,
    SUB_TDATA = 4'd8
  } sub_e;

  typedef enum logic [3:0] {
    ST_HMARK, ST_HLEN, ST_HWORDS, ST_TMARK, ST_TLEN, ST_TBODY,
    ST_DMARK, ST_DLEN, ST_DBODY, ST_ENDPEND, ST_DONE, ST_HALT, ST_DIV, ST_OUT
  } state_e;

  function automatic logic [7:0] mark_byte(input logic head, input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0: r = 8'h4d;
      2'd1: r = 8'h54;
      2'd2: r = head ? 8'h68 : 8'h72;
      default: r = head ? 8'h64 : 8'h6b;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ src/midi_note_stream_parser_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// midi_note_stream_parser_core: byte-serial standard MIDI file parser
// Checks chunk markers, reports header words, tempos and transposed note-ons.
// ----------------------------------------------------------------------------
// Feed the file one byte per beat on file_byte_i. A byte is accepted, its
// result (if any) goes into the output register and the next byte may
// follow at once. The exception is the last byte of an FF 51 03 tempo event
// with a nonzero tempo, in either track: 60000000 / tempo runs in a shared
// restoring divider, one quotient bit per cycle, and the input stalls through
// the divide (ST_DIV) and the result load (ST_OUT). Any byte also waits while
// an earlier result is still unclaimed downstream. After a bad chunk marker,
// or after the data track ends, all bytes are accepted and dropped until
// reset. The user must write cfg_wdata_i only while the block is idle, which
// the block does not enforce; the value adds to every reported key modulo 256.
module midi_note_stream_parser_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  file_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       result_kind_o,
  output logic [7:0]       note_key_o,
  output logic [31:0]      delta_ticks_o,
  output logic [25:0]      beats_per_minute_o,
  output logic [15:0]      file_format_o,
  output logic [15:0]      track_count_o,
  output logic [15:0]      ticks_per_quarter_o
);
  import mnsp_pkg::*;

  state_e      state_q, state_d;
  sub_e        sub_q, sub_d;
  logic [2:0]  idx_q, idx_d;      // byte index inside marker/length/words
  logic [31:0] clen_q, clen_d;
  logic [31:0] seen_q, seen_d;
  logic [27:0] vlq_q, vlq_d;
  logic [31:0] tick_q, tick_d;
  logic [7:0]  skip_q, skip_d;
  logic [31:0] gath_q, gath_d;
  logic [7:0]  key_q, key_d;
  logic [7:0]  shift_q;
  logic        lastt_q, lastt_d;  // tempo was the track's last byte
  logic        ddat_q, ddat_d;    // tempo came from the data track

  // divider
  logic [23:0] dvs_q, dvs_d;
  logic [25:0] quo_q, quo_d;
  logic [24:0] rem_q, rem_d;
  logic [4:0]  cnt_q, cnt_d;

  logic        ov_q, ov_d;
  logic [2:0]  ok_q, ok_d;
  logic [7:0]  okey_q, okey_d;
  logic [31:0] otick_q, otick_d;
  logic [25:0] obpm_q, obpm_d;
  logic [15:0] of_q, of_d, ot_q, ot_d, od_q, od_d;

  logic accept, out_free;
  logic [24:0] rem_sh;
  logic [25:0] rem_sub;

  assign out_free   = !ov_q || !out_stall_i;
  assign in_stall_o = (state_q == ST_DIV) || (state_q == ST_OUT) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  assign rem_sh  = {rem_q[23:0], MicrosPerMin[cnt_q]};
  assign rem_sub = {1'b0, rem_sh} - {2'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HMARK;
      sub_q   <= SUB_DELTA;
      idx_q   <= '0;
      clen_q  <= '0;
      seen_q  <= '0;
      vlq_q   <= '0;
      tick_q  <= '0;
      skip_q  <= '0;
      gath_q  <= '0;
      key_q   <= '0;
      shift_q <= '0;
      lastt_q <= 1'b0;
      ddat_q  <= 1'b0;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      sub_q   <= sub_d;
      idx_q   <= idx_d;
      clen_q  <= clen_d;
      seen_q  <= seen_d;
      vlq_q   <= vlq_d;
      tick_q  <= tick_d;
      skip_q  <= skip_d;
      gath_q  <= gath_d;
      key_q   <= key_d;
      lastt_q <= lastt_d;
      ddat_q  <= ddat_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
      if (cfg_we_i) begin
        shift_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dvs_q   <= dvs_d;
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    ok_q    <= ok_d;
    okey_q  <= okey_d;
    otick_q <= otick_d;
    obpm_q  <= obpm_d;
    of_q    <= of_d;
    ot_q    <= ot_d;
    od_q    <= od_d;
  end

  always_comb begin
    logic        emit, body, data, last;
    logic [2:0]  kind;
    logic [32:0] tsum;
    logic [27:0] vnew;
    sub_e        sb;
    state_d = state_q; sub_d = sub_q; idx_d = idx_q; clen_d = clen_q;
    seen_d = seen_q; vlq_d = vlq_q; tick_d = tick_q; skip_d = skip_q;
    gath_d = gath_q; key_d = key_q; lastt_d = lastt_q; ddat_d = ddat_q;
    dvs_d = dvs_q; quo_d = quo_q; rem_d = rem_q; cnt_d = cnt_q;
    ok_d = ok_q; okey_d = okey_q; otick_d = otick_q; obpm_d = obpm_q;
    of_d = of_q; ot_d = ot_q; od_d = od_q;
    ov_d = ov_q && out_stall_i;
    emit = 1'b0; kind = KIND_HEADER; body = 1'b0; data = 1'b0; last = 1'b0;
    tsum = '0; vnew = '0; sb = sub_q;

    // hold the result fields at zero unless a kind fills them
    if (state_q == ST_DIV) begin
      rem_d = rem_sub[25] ? rem_sh : rem_sub[24:0];
      quo_d = {quo_q[24:0], !rem_sub[25]};
      if (cnt_q == 5'd0) state_d = ST_OUT;
      else cnt_d = cnt_q - 5'd1;
    end else if (state_q == ST_OUT) begin
      if (out_free) begin
        emit = 1'b1; kind = KIND_TEMPO;
        // return to the track body, or finish the track the tempo closed
        if (lastt_q) state_d = ddat_q ? ST_ENDPEND : ST_DMARK;
        else state_d = ddat_q ? ST_DBODY : ST_TBODY;
        idx_d = '0;
      end
    end else if (accept) begin
      case (state_q)
        ST_HMARK, ST_TMARK, ST_DMARK: begin
          if (file_byte_i == mark_byte(state_q == ST_HMARK, idx_q[1:0])) begin
            idx_d = idx_q + 3'd1;
            if (idx_q == 3'd3) begin
              idx_d = '0;
              state_d = (state_q == ST_HMARK) ? ST_HLEN :
                        (state_q == ST_TMARK) ? ST_TLEN : ST_DLEN;
            end
          end else begin
            emit = 1'b1; kind = KIND_BAD_MRK; state_d = ST_HALT;
          end
        end
        ST_HLEN: begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd3) begin
            idx_d = '0; state_d = ST_HWORDS;
          end
        end
        ST_HWORDS: begin
          idx_d = idx_q + 3'd1;
          if (idx_q < 3'd4) gath_d = {gath_q[23:0], file_byte_i};
          else clen_d = {16'd0, clen_q[7:0], file_byte_i};
          if (idx_q == 3'd5) begin
            emit = 1'b1; kind = KIND_HEADER;
            of_d = gath_q[31:16]; ot_d = gath_q[15:0];
            od_d = {clen_q[7:0], file_byte_i};
            clen_d = '0; idx_d = '0; state_d = ST_TMARK;
          end
        end
        ST_TLEN, ST_DLEN: begin
          clen_d = {clen_q[23:0], file_byte_i};
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd3) begin
            idx_d = '0; seen_d = '0; vlq_d = '0; sub_d = SUB_DELTA;
            if ({clen_q[23:0], file_byte_i} == 32'd0) begin
              if (state_q == ST_DLEN) begin
                emit = 1'b1; kind = KIND_END; state_d = ST_DONE;
              end else begin
                state_d = ST_DMARK;
              end
            end else begin
              state_d = (state_q == ST_DLEN) ? ST_DBODY : ST_TBODY;
            end
          end
        end
        ST_TBODY, ST_DBODY: begin
          body = 1'b1;
          data = (state_q == ST_DBODY);
        end
        ST_ENDPEND: begin
          emit = 1'b1; kind = KIND_END; state_d = ST_DONE;
        end
        default: begin
        end
      endcase
    end

    if (body) begin
      seen_d = seen_q + 32'd1;
      last = (seen_q + 32'd1) >= clen_q;
      case (sub_q)
        SUB_DELTA: begin
          vnew = {vlq_q[20:0], file_byte_i[6:0]};
          vlq_d = vnew;
          if (!file_byte_i[7]) begin
            if (data) begin
              tsum = {1'b0, tick_q} + {5'd0, vnew};
              tick_d = tsum[32] ? '1 : tsum[31:0];
            end
            vlq_d = '0; sb = SUB_STATUS;
          end
        end
        SUB_STATUS: begin
          if (file_byte_i == 8'hFF) sb = SUB_MKIND;
          else if (!data) sb = SUB_DELTA;
          else begin
            case (file_byte_i[7:4])
              4'h9: sb = SUB_KEY;
              4'h8, 4'hA, 4'hB, 4'hE: begin skip_d = 8'd2; sb = SUB_SKIP; end
              4'hC, 4'hD: begin skip_d = 8'd1; sb = SUB_SKIP; end
              default: sb = SUB_DELTA;
            endcase
          end
        end
        SUB_KEY: begin key_d = file_byte_i; sb = SUB_VEL; end
        SUB_VEL: begin
          emit = 1'b1; kind = KIND_NOTE;
          okey_d = key_q + shift_q; otick_d = tick_q;
          tick_d = '0; sb = SUB_DELTA;
        end
        SUB_SKIP: begin
          if (skip_q <= 8'd1) begin skip_d = '0; sb = SUB_DELTA; end
          else skip_d = skip_q - 8'd1;
        end
        SUB_MKIND: begin
          sb = SUB_SKIP;
          case (file_byte_i)
            8'h51: sb = SUB_TLEN;
            8'h54: skip_d = 8'd6;
            8'h58: skip_d = 8'd5;
            8'h00, 8'h59: skip_d = 8'd3;
            8'h20: skip_d = 8'd2;
            8'h2F: skip_d = 8'd1;
            default: sb = SUB_MLEN;
          endcase
        end
        SUB_MLEN: begin
          skip_d = file_byte_i;
          sb = (file_byte_i != 8'd0) ? SUB_SKIP : SUB_DELTA;
        end
        SUB_TLEN: begin
          if (file_byte_i == 8'h03) begin
            gath_d = '0; skip_d = 8'd3; sb = SUB_TDATA;
          end else begin
            skip_d = file_byte_i;
            sb = (file_byte_i != 8'd0) ? SUB_SKIP : SUB_DELTA;
          end
        end
        SUB_TDATA: begin
          gath_d = {8'd0, gath_q[15:0], file_byte_i};
          if (skip_q <= 8'd1) begin
            skip_d = '0; sb = SUB_DELTA;
            if ({gath_q[15:0], file_byte_i} == 24'd0) begin
              emit = 1'b1; kind = KIND_TEMPO; obpm_d = '0;
            end else begin
              // advance into the divider; the result comes out of ST_OUT
              dvs_d = {gath_q[15:0], file_byte_i};
              rem_d = '0; quo_d = '0; cnt_d = 5'(BpmWidth - 1);
              state_d = ST_DIV;
            end
          end else begin
            skip_d = skip_q - 8'd1;
          end
        end
        default: sb = SUB_DELTA;
      endcase
      sub_d = sb;
      lastt_d = last;
      ddat_d = data;
      if (last) begin
        vlq_d = '0;
        // a pending tempo finishes the track from ST_OUT
        if (state_d != ST_DIV) begin
          if (!data) begin
            state_d = ST_DMARK; idx_d = '0;
          end else if (emit) begin
            state_d = ST_ENDPEND;
          end else begin
            emit = 1'b1; kind = KIND_END; state_d = ST_DONE;
          end
        end
      end
    end

    if (state_q == ST_OUT && emit) obpm_d = quo_q;

    if (emit) begin
      ov_d = 1'b1;
      ok_d = kind;
      if (kind != KIND_NOTE) begin okey_d = '0; otick_d = '0; end
      if (kind != KIND_TEMPO) obpm_d = '0;
      if (kind != KIND_HEADER) begin of_d = '0; ot_d = '0; od_d = '0; end
    end
  end

  assign out_valid_o         = ov_q;
  assign result_kind_o       = ok_q;
  assign note_key_o          = okey_q;
  assign delta_ticks_o       = otick_q;
  assign beats_per_minute_o  = obpm_q;
  assign file_format_o       = of_q;
  assign track_count_o       = ot_q;
  assign ticks_per_quarter_o = od_q;

  // Input is never taken while the divider owns the sequencer.
  a_no_accept_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> in_stall_o) else $error("byte accepted during divide");
  // A waiting result is never overwritten.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(result_kind_o)))
    else $error("result lost");
  // The divider always finishes by loading the tempo result.
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && cnt_q == 5'd0) |=> (state_q == ST_OUT))
    else $error("divider did not finish");

endmodule
`default_nettype wire

@@ verif/midi_note_stream_parser_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// midi_note_stream_parser_core_tb: self-checking bench for the MIDI parser
// Streams one generated MIDI file through the parser under random input gaps
// and output stalls. A behavioral parser predicts every result on each
// accepted byte, and each result beat is checked field by field, in order.
// ----------------------------------------------------------------------------
module midi_note_stream_parser_core_tb;
  import mnsp_pkg::*;

  // Chunk tags, most significant byte first
  localparam logic [31:0] HEAD_TAG  = 32'h4d546864;
  localparam logic [31:0] TRACK_TAG = 32'h4d54726b;

  // Status nibbles and meta types
  localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
  localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
  localparam logic [3:0] NIB_POLY_AT  = 4'hA;
  localparam logic [3:0] NIB_CTRL     = 4'hB;
  localparam logic [3:0] NIB_PROGRAM  = 4'hC;
  localparam logic [3:0] NIB_CHAN_AT  = 4'hD;
  localparam logic [3:0] NIB_BEND     = 4'hE;
  localparam logic [7:0] META_LEAD    = 8'hFF;
  localparam logic [7:0] META_TEMPO   = 8'h51;
  localparam logic [7:0] META_SMPTE   = 8'h54;
  localparam logic [7:0] META_TIMESIG = 8'h58;
  localparam logic [7:0] META_SEQNUM  = 8'h00;
  localparam logic [7:0] META_KEYSIG  = 8'h59;
  localparam logic [7:0] META_CHANPFX = 8'h20;
  localparam logic [7:0] META_EOT     = 8'h2F;
  localparam logic [7:0] TEMPO_LEN    = 8'h03;

  localparam int CFG_QUIET = 48;
  localparam int WATCHDOG  = 3000;

  typedef struct packed {
    logic       is_cfg;
    logic [7:0] val;
  } beat_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  key;
    logic [31:0] ticks;
    logic [25:0] bpm;
    logic [15:0] fmt;
    logic [15:0] trk;
    logic [15:0] tpq;
  } parse_res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [7:0]  cfg_wdata;
  logic        in_valid;
  logic        in_stall_o;
  logic [7:0]  file_byte;
  logic        out_valid_o;
  logic        out_stall;
  logic [2:0]  result_kind_o;
  logic [7:0]  note_key_o;
  logic [31:0] delta_ticks_o;
  logic [25:0] beats_per_minute_o;
  logic [15:0] file_format_o;
  logic [15:0] track_count_o;
  logic [15:0] ticks_per_quarter_o;

  midi_note_stream_parser_core i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we),
    .cfg_wdata_i        (cfg_wdata),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall_o),
    .file_byte_i        (file_byte),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall),
    .result_kind_o      (result_kind_o),
    .note_key_o         (note_key_o),
    .delta_ticks_o      (delta_ticks_o),
    .beats_per_minute_o (beats_per_minute_o),
    .file_format_o      (file_format_o),
    .track_count_o      (track_count_o),
    .ticks_per_quarter_o(ticks_per_quarter_o)
  );

  beat_t      file_q[$];     // bytes and shift writes still to send
  parse_res_t parsed_q[$];   // results predicted but not yet seen
  int         errors;

  // ---------------------------------------------------------------------------
  // Behavioral parser state
  // ---------------------------------------------------------------------------
  state_e      ph;
  int unsigned pos;
  sub_e        sub;
  logic [31:0] hdr_words;
  logic [15:0] division;
  logic [31:0] chunk_len;
  logic [31:0] chunk_seen;
  logic [27:0] vlq;
  logic [31:0] tick_sum;
  logic [23:0] tempo_acc;
  logic [7:0]  skip_cnt;
  logic [7:0]  held_key;
  logic [7:0]  shift;

  task automatic clear_parser();
    ph = ST_HMARK;
    pos = 0;
    sub = SUB_DELTA;
    hdr_words = '0;
    division = '0;
    chunk_len = '0;
    chunk_seen = '0;
    vlq = '0;
    tick_sum = '0;
    tempo_acc = '0;
    skip_cnt = '0;
    held_key = '0;
    shift = '0;
  endtask

  // Advance the parser by one file byte and queue the result it yields, if any.
  task automatic parse_byte(input logic [7:0] b);
    parse_res_t  r;
    logic        hit;
    logic        data;
    logic [32:0] total;
    logic [31:0] quot;
    logic [7:0]  tag;
    r = '0;
    r.kind = KIND_HEADER;
    hit = 1'b0;
    data = (ph == ST_DBODY);
    case (ph)
      ST_HMARK, ST_TMARK, ST_DMARK: begin
        tag = (ph == ST_HMARK) ? HEAD_TAG[31-8*pos -: 8] : TRACK_TAG[31-8*pos -: 8];
        if (b == tag) begin
          pos++;
          if (pos == 4) begin
            pos = 0;
            if (ph == ST_HMARK) ph = ST_HLEN;
            else if (ph == ST_TMARK) ph = ST_TLEN;
            else ph = ST_DLEN;
          end
        end else begin
          // a wrong tag byte halts parsing for good
          ph = ST_HALT;
          r.kind = KIND_BAD_MRK;
          hit = 1'b1;
        end
      end
      ST_HLEN: begin
        pos++;
        if (pos == 4) begin
          pos = 0;
          ph = ST_HWORDS;
        end
      end
      ST_HWORDS: begin
        if (pos < 4) hdr_words = {hdr_words[23:0], b};
        else division = {division[7:0], b};
        pos++;
        if (pos == 6) begin
          r.kind = KIND_HEADER;
          r.fmt = hdr_words[31:16];
          r.trk = hdr_words[15:0];
          r.tpq = division;
          hit = 1'b1;
          pos = 0;
          ph = ST_TMARK;
        end
      end
      ST_TLEN, ST_DLEN: begin
        chunk_len = {chunk_len[23:0], b};
        pos++;
        if (pos == 4) begin
          pos = 0;
          chunk_seen = '0;
          vlq = '0;
          sub = SUB_DELTA;
          if (chunk_len == 0) begin
            // an empty data track ends at once, an empty tempo track is skipped
            if (ph == ST_DLEN) begin
              r.kind = KIND_END;
              hit = 1'b1;
              ph = ST_DONE;
            end else begin
              ph = ST_DMARK;
            end
          end else begin
            ph = (ph == ST_TLEN) ? ST_TBODY : ST_DBODY;
          end
        end
      end
      ST_TBODY, ST_DBODY: begin
        chunk_seen++;
        case (sub)
          SUB_DELTA: begin
            vlq = {vlq[20:0], b[6:0]};
            if (!b[7]) begin
              // only the data track accumulates ticks; saturate at all ones
              if (data) begin
                total = {1'b0, tick_sum} + vlq;
                tick_sum = total[32] ? '1 : total[31:0];
              end
              vlq = '0;
              sub = SUB_STATUS;
            end
          end
          SUB_STATUS: begin
            if (b == META_LEAD) sub = SUB_MKIND;
            else if (!data) sub = SUB_DELTA;
            else begin
              case (b[7:4])
                NIB_NOTE_ON: sub = SUB_KEY;
                NIB_NOTE_OFF, NIB_POLY_AT, NIB_CTRL, NIB_BEND: begin
                  skip_cnt = 8'd2;
                  sub = SUB_SKIP;
                end
                NIB_PROGRAM, NIB_CHAN_AT: begin
                  skip_cnt = 8'd1;
                  sub = SUB_SKIP;
                end
                default: sub = SUB_DELTA;
              endcase
            end
          end
          SUB_KEY: begin
            held_key = b;
            sub = SUB_VEL;
          end
          SUB_VEL: begin
            r.kind = KIND_NOTE;
            r.key = held_key + shift;
            r.ticks = tick_sum;
            hit = 1'b1;
            tick_sum = '0;
            sub = SUB_DELTA;
          end
          SUB_SKIP: begin
            if (skip_cnt <= 1) begin
              skip_cnt = '0;
              sub = SUB_DELTA;
            end else begin
              skip_cnt--;
            end
          end
          SUB_MKIND: begin
            sub = SUB_SKIP;
            case (b)
              META_TEMPO:               sub = SUB_TLEN;
              META_SMPTE:               skip_cnt = 8'd6;
              META_TIMESIG:             skip_cnt = 8'd5;
              META_SEQNUM, META_KEYSIG: skip_cnt = 8'd3;
              META_CHANPFX:             skip_cnt = 8'd2;
              META_EOT:                 skip_cnt = 8'd1;
              default:                  sub = SUB_MLEN;
            endcase
          end
          SUB_MLEN: begin
            skip_cnt = b;
            sub = (b != 0) ? SUB_SKIP : SUB_DELTA;
          end
          SUB_TLEN: begin
            if (b == TEMPO_LEN) begin
              tempo_acc = '0;
              skip_cnt = 8'd3;
              sub = SUB_TDATA;
            end else begin
              skip_cnt = b;
              sub = (b != 0) ? SUB_SKIP : SUB_DELTA;
            end
          end
          default: begin
            tempo_acc = {tempo_acc[15:0], b};
            if (skip_cnt <= 1) begin
              skip_cnt = '0;
              quot = (tempo_acc != 0) ? MicrosPerMin / tempo_acc : '0;
              r.kind = KIND_TEMPO;
              r.bpm = quot[25:0];
              hit = 1'b1;
              sub = SUB_DELTA;
            end else begin
              skip_cnt--;
            end
          end
        endcase
        // chunk end cuts any unfinished event
        if (chunk_seen >= chunk_len) begin
          vlq = '0;
          if (!data) begin
            ph = ST_DMARK;
            pos = 0;
          end else if (hit) begin
            ph = ST_ENDPEND;
          end else begin
            r = '0;
            r.kind = KIND_END;
            hit = 1'b1;
            ph = ST_DONE;
          end
        end
      end
      ST_ENDPEND: begin
        r.kind = KIND_END;
        hit = 1'b1;
        ph = ST_DONE;
      end
      default: ;
    endcase
    if (hit) parsed_q.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // File builder
  // ---------------------------------------------------------------------------
  task automatic put(input logic [7:0] b);
    file_q.push_back(beat_t'{is_cfg: 1'b0, val: b});
  endtask

  task automatic put_cfg(input logic [7:0] v);
    file_q.push_back(beat_t'{is_cfg: 1'b1, val: v});
  endtask

  task automatic put_rand(input int n);
    for (int i = 0; i < n; i++) put(8'($urandom));
  endtask

  task automatic put_vlq(input logic [27:0] v);
    int n;
    n = 1;
    for (int i = 1; i < 4; i++) if ((v >> (7 * i)) != 0) n = i + 1;
    for (int i = n - 1; i >= 0; i--) put({i != 0, v[7*i +: 7]});
  endtask

  task automatic put_tempo(input logic [23:0] t);
    put(META_LEAD);
    put(META_TEMPO);
    put(TEMPO_LEN);
    put(t[23:16]);
    put(t[15:8]);
    put(t[7:0]);
  endtask

  task automatic put_note(input logic [7:0] key);
    put({NIB_NOTE_ON, 4'($urandom)});
    put(key);
    put(8'($urandom));
  endtask

  // Random delta followed by a random event, weighted toward notes.
  task automatic put_event();
    int          pick;
    logic [7:0]  m;
    logic [7:0]  fixed[6];
    fixed = '{META_SMPTE, META_TIMESIG, META_SEQNUM, META_KEYSIG, META_CHANPFX, META_EOT};
    pick = $urandom_range(99);
    if (pick < 80) put_vlq(28'($urandom_range(127)));
    else if (pick < 95) put_vlq(28'($urandom_range(32'h1FFFFF)));
    else begin
      // five byte delta keeps only its low 28 bits
      repeat (4) put(8'h80 | 8'($urandom));
      put(8'($urandom_range(127)));
    end
    pick = $urandom_range(99);
    if (pick < 45) put_note(8'($urandom));
    else if (pick < 60) begin
      case ($urandom_range(3))
        0: put({NIB_NOTE_OFF, 4'($urandom)});
        1: put({NIB_POLY_AT, 4'($urandom)});
        2: put({NIB_CTRL, 4'($urandom)});
        default: put({NIB_BEND, 4'($urandom)});
      endcase
      put_rand(2);
    end else if (pick < 68) begin
      put({($urandom_range(1) != 0) ? NIB_PROGRAM : NIB_CHAN_AT, 4'($urandom)});
      put_rand(1);
    end else if (pick < 74) put(8'($urandom_range(8'h7F)));
    else if (pick < 78) put(8'($urandom_range(8'hF0, 8'hFE)));
    else if (pick < 92) begin
      m = fixed[$urandom_range(5)];
      put(META_LEAD);
      put(m);
      case (m)
        META_SMPTE:               put_rand(6);
        META_TIMESIG:             put_rand(5);
        META_SEQNUM, META_KEYSIG: put_rand(3);
        META_CHANPFX:             put_rand(2);
        default:                  put_rand(1);
      endcase
    end else if (pick < 95) put_tempo(24'($urandom));
    else begin
      m = 8'($urandom);
      if (m == META_TEMPO || m == META_SMPTE || m == META_TIMESIG || m == META_SEQNUM ||
          m == META_KEYSIG || m == META_CHANPFX || m == META_EOT) m = 8'h7F;
      put(META_LEAD);
      put(m);
      pick = $urandom_range(6);
      put(8'(pick));
      put_rand(pick);
    end
  endtask

  // Count the file bytes from index start on, leaving shift writes out.
  function automatic int bytes_from(input int start);
    int n;
    n = 0;
    for (int i = start; i < file_q.size(); i++) if (!file_q[i].is_cfg) n++;
    return n;
  endfunction

  task automatic patch_len(input int at, input logic [31:0] len);
    for (int k = 0; k < 4; k++) file_q[at + k].val = len[31-8*k -: 8];
  endtask

  task automatic build_file();
    int          len_at;
    int          body_at;
    int          next_cfg;
    int          cfg_idx;
    int          n;
    logic [7:0]  shifts[4];
    shifts = '{8'h7F, 8'h81, 8'($urandom), 8'h00};
    put_cfg(8'($urandom));
    // header: tag, ignored length, format, track count, division
    for (int i = 0; i < 4; i++) put(HEAD_TAG[31-8*i -: 8]);
    put_rand(4);
    put_rand(6);
    // tempo track with every meta flavor, cut inside a final tempo event
    for (int i = 0; i < 4; i++) put(TRACK_TAG[31-8*i -: 8]);
    len_at = file_q.size();
    put_rand(4);
    put_vlq(0);          put_tempo(24'h000000);
    put_vlq(28'd128);    put_tempo(24'h000001);
    put(8'hFF); put(8'hFF); put(8'hFF); put(8'h7F);
    put_tempo(24'hFFFFFF);
    put_vlq(0);  put(META_LEAD); put(META_TEMPO); put(8'h02); put_rand(2);
    put_vlq(0);  put(META_LEAD); put(META_TEMPO); put(8'h00);
    put_vlq(0);  put(8'h45);
    put_vlq(0);  put(META_LEAD); put(META_SMPTE);   put_rand(6);
    put_vlq(0);  put(META_LEAD); put(META_TIMESIG); put_rand(5);
    put_vlq(0);  put(META_LEAD); put(META_SEQNUM);  put_rand(3);
    put_vlq(0);  put(META_LEAD); put(META_KEYSIG);  put_rand(3);
    put_vlq(0);  put(META_LEAD); put(META_CHANPFX); put_rand(2);
    put_vlq(0);  put(META_LEAD); put(META_EOT);     put_rand(1);
    put_vlq(0);  put(META_LEAD); put(8'h7F); put(8'h02); put_rand(2);
    put_vlq(0);  put(META_LEAD); put(8'h01); put(8'h00);
    put_vlq(0);  put(META_LEAD); put(META_TEMPO); put(TEMPO_LEN); put(8'h07);
    patch_len(len_at, bytes_from(len_at + 4));
    // data track
    for (int i = 0; i < 4; i++) put(TRACK_TAG[31-8*i -: 8]);
    len_at = file_q.size();
    put_rand(4);
    body_at = file_q.size();
    put_vlq(0);  put_note(8'hFF);
    put_vlq(0);  put_note(8'h00);
    // drive the tick sum into saturation
    repeat (20) begin
      put(8'hFF); put(8'hFF); put(8'hFF); put(8'h7F);
      put(8'h01);
    end
    put_vlq(0);  put_note(8'h3C);
    put_vlq(0);  put_tempo(24'($urandom));
    next_cfg = 350;
    cfg_idx = 0;
    while (bytes_from(body_at) < 1400) begin
      if (cfg_idx < 4 && bytes_from(body_at) >= next_cfg) begin
        put_cfg(shifts[cfg_idx]);
        cfg_idx++;
        next_cfg += 350;
      end
      put_event();
    end
    put_vlq(28'd5);
    put_note(8'($urandom));
    n = bytes_from(body_at);
    // either end exactly on a note or cut the track short
    if ($urandom_range(1) == 0) n -= $urandom_range(1, 3);
    patch_len(len_at, n);
    put_rand(16);
  endtask

  // Mostly back to back, sometimes short gaps, now and then a long one.
  function automatic int gap_len();
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    errors++;
  endtask

  task automatic check_result();
    parse_res_t w;
    if (parsed_q.size() == 0) begin
      report($sformatf("unexpected result beat, kind %0d", result_kind_o));
      return;
    end
    w = parsed_q.pop_front();
    if (result_kind_o != w.kind)
      report($sformatf("kind %0d, want %0d", result_kind_o, w.kind));
    if (note_key_o != w.key)
      report($sformatf("note_key %h, want %h", note_key_o, w.key));
    if (delta_ticks_o != w.ticks)
      report($sformatf("delta_ticks %h, want %h", delta_ticks_o, w.ticks));
    if (beats_per_minute_o != w.bpm)
      report($sformatf("bpm %0d, want %0d", beats_per_minute_o, w.bpm));
    if (file_format_o != w.fmt)
      report($sformatf("file_format %h, want %h", file_format_o, w.fmt));
    if (track_count_o != w.trk)
      report($sformatf("track_count %h, want %h", track_count_o, w.trk));
    if (ticks_per_quarter_o != w.tpq)
      report($sformatf("ticks_per_quarter %h, want %h", ticks_per_quarter_o, w.tpq));
  endtask

  // ---------------------------------------------------------------------------
  // Byte driver: hold a stalled beat, otherwise advance through file_q. Shift
  // writes wait until every predicted result is out and the parser has idled.
  // ---------------------------------------------------------------------------
  int in_gap;
  int in_calm;
  int quiet;

  always @(posedge clk_i or negedge rst_ni) begin
    beat_t nb;
    logic  v_nxt;
    logic  we_nxt;
    if (!rst_ni) begin
      in_valid  <= 1'b0;
      file_byte <= '0;
      cfg_we    <= 1'b0;
      cfg_wdata <= '0;
      in_gap = 0;
      in_calm = 0;
      quiet = 0;
      clear_parser();
    end else begin
      v_nxt = in_valid;
      we_nxt = 1'b0;
      if (in_valid || parsed_q.size() != 0) quiet = 0;
      else quiet++;
      if (in_valid && !in_stall_o) begin
        parse_byte(file_byte);
        v_nxt = 1'b0;
      end
      if (!(in_valid && in_stall_o)) begin
        if (in_gap > 0) begin
          in_gap--;
          v_nxt = 1'b0;
        end else if (file_q.size() != 0) begin
          if (file_q[0].is_cfg) begin
            v_nxt = 1'b0;
            if (parsed_q.size() == 0 && quiet >= CFG_QUIET) begin
              nb = file_q.pop_front();
              we_nxt = 1'b1;
              cfg_wdata <= nb.val;
              shift = nb.val;
            end
          end else begin
            nb = file_q.pop_front();
            v_nxt = 1'b1;
            file_byte <= nb.val;
            // stretches of back-to-back bytes between gappy spells
            if (in_calm > 0) begin
              in_calm--;
              in_gap = 0;
            end else if ($urandom_range(99) == 0) begin
              in_calm = $urandom_range(40, 150);
              in_gap = 0;
            end else begin
              in_gap = gap_len();
            end
          end
        end else begin
          v_nxt = 1'b0;
        end
      end
      in_valid <= v_nxt;
      cfg_we   <= we_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: check each accepted beat, stall at random
  // ---------------------------------------------------------------------------
  int out_hold;
  int out_calm;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      out_hold = 0;
      out_calm = 0;
    end else begin
      if (out_valid_o && !out_stall) check_result();
      if (out_hold > 0) begin
        out_hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (out_calm > 0) out_calm--;
        else if ($urandom_range(99) == 0) out_calm = $urandom_range(40, 150);
        else out_hold = gap_len();
      end
    end
  end

  // Drop the run when nothing moves on either side for too long.
  int stuck;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
      stuck = 0;
    end else begin
      stuck++;
      if (stuck == WATCHDOG) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    errors = 0;
    rst_ni = 1'b0;
    build_file();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    // drain: all bytes sent, all results seen, then a short settle
    while (file_q.size() != 0 || in_valid || parsed_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (errors == 0 && parsed_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ midi_note_stream_parser_core.f @@
src/mnsp_pkg.sv
src/midi_note_stream_parser_core.sv
verif/midi_note_stream_parser_core_tb.sv
